// ===== design/bfl_pkg.sv =====
// shared types, constants and the exp node table builder for the burner lag model
package bfl_pkg;

   localparam int TIME_W      = 32;
   localparam int TEMP_W      = 24;
   localparam int FLOW_W      = 16;
   localparam int POWER_W     = 16;
   localparam int TAU_W       = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam int TEMP_MAX = 8388607;
   localparam int TEMP_MIN = -8388608;

   // 10 * 256 : power/flow ratio scaled back to 1/256 degree
   localparam int HEAT_GAIN = 2560;
   // burner * HEAT_GAIN + flow/2 fits in this many bits
   localparam int RATIO_W   = 28;

   localparam int EXP_RANGE      = 16;
   localparam int EXP_RANGE_LOG2 = 4;
   // tau * EXP_RANGE
   localparam int SPAN_W         = TAU_W + EXP_RANGE_LOG2;

   localparam int TQ           = 30;
   localparam int NODE_W       = 32;
   localparam int TAYLOR_TERMS = 24;
   localparam int EXP_SEG_MAX  = 1024;
   localparam logic [63:0] TQ_ONE = 64'd1 << TQ;

   localparam int DEF_FRACTION_BITS = 16;
   localparam int DEF_EXP_SEGMENTS  = 64;

   localparam logic signed [TEMP_W-1:0] RST_INIT_INLET = 24'sd12800;
   localparam logic [FLOW_W-1:0]        RST_INIT_FLOW  = 16'd2560;
   localparam logic [POWER_W-1:0]       RST_INIT_BURNER = 16'd5120;
   localparam logic [TAU_W-1:0]         RST_TAU        = 16'd300;

   localparam int DIV_CNT_W = 6;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] iters;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef logic [NODE_W-1:0] node_tbl_type [0:EXP_SEG_MAX];

   // shift and subtract quotient, only evaluated while building constants
   function automatic logic [63:0] shift_sub_div(input logic [63:0] num,
                                                 input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      int          b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-16k/segs) nodes in Q2.30, built from a truncated taylor base
   function automatic node_tbl_type exp_node_table(input int segs, input logic [63:0] step);
      node_tbl_type tbl;
      logic [63:0]  term;
      logic [63:0]  base;
      logic [63:0]  acc;
      longint       sum;
      int           n;
      int           k;
      tbl  = '{default: '0};
      term = TQ_ONE;
      sum  = longint'(TQ_ONE);
      for (n = 1; n <= TAYLOR_TERMS; n++) begin
         term = shift_sub_div(term * step, 64'(n) << TQ);
         if (n[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      base   = (sum > 0) ? 64'(sum) : 64'd0;
      tbl[0] = NODE_W'(TQ_ONE);
      for (k = 1; k <= EXP_SEG_MAX; k++) begin
         if (k <= segs) begin
            acc    = 64'(tbl[k-1]) * base + (TQ_ONE >> 1);
            tbl[k] = NODE_W'(acc >> TQ);
         end
      end
      return tbl;
   endfunction

endpackage

// ===== design/bfl_divider.sv =====
// shared restoring divider, one quotient bit per cycle
module bfl_divider
   import bfl_pkg::*;
#(
   parameter int DIV_W = SPAN_W,
   parameter int QUO_W = RATIO_W
) (
   input  logic               clock,
   input  logic               reset,
   input  div_ctrl_type       ctrl,
   input  logic [DIV_W-1:0]   rem_init,
   input  logic [QUO_W-1:0]   num,
   input  logic [DIV_W-1:0]   divisor,
   output div_stat_type       stat,
   output logic [QUO_W-1:0]   quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     sh_ff, sh_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W:0]       trial_diff;
   logic                 fits;

   // shift the next numerator bit into the partial remainder
   assign trial      = {rem_ff, sh_ff[QUO_W-1]};
   assign fits       = trial >= {1'b0, dvs_ff};
   assign trial_diff = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      dvs_in  = dvs_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctrl.iters;
         rem_in  = rem_init;
         sh_in   = num;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         rem_in = fits ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
         sh_in  = {sh_ff[QUO_W-2:0], fits};
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = sh_ff;

endmodule

// ===== design/bfl_node_rom.sv =====
// exp node table with a registered read port
module bfl_node_rom
   import bfl_pkg::*;
#(
   parameter int EXP_SEGMENTS = DEF_EXP_SEGMENTS
) (
   input  logic                                 clock,
   input  logic [$clog2(EXP_SEGMENTS+1)-1:0]    rd_addr,
   output logic [NODE_W-1:0]                    rd_data
);

   localparam logic [63:0] EXP_STEP = (64'(EXP_RANGE) << TQ) / EXP_SEGMENTS;
   localparam node_tbl_type NODE_TBL = exp_node_table(EXP_SEGMENTS, EXP_STEP);

   logic [NODE_W-1:0] node_rom [EXP_SEGMENTS+1];
   logic [NODE_W-1:0] rd_data_ff;

   for (genvar k = 0; k <= EXP_SEGMENTS; k++) begin : g_node
      assign node_rom[k] = NODE_TBL[k];
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= node_rom[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/burner_first_order_lag_sim.sv =====
// burner first-order lag plant model, top level with step sequencer
//
// usage:
//   req_ channel: one request per simulation step carrying the time stamp in ms
//   and the inlet temperature, flow and burner power that hold from then on.
//   rsp_ channel: one outlet temperature and fault flag per request.
//   csr_ channel: writes the initial inlet/flow/burner values and tau_ms; always
//   ready, meant to be written while no request is in flight.
// timing:
//   one request at a time; req_ready is high only while the sequencer idles.
//   a step runs the ratio division (28 quotient bits) and the lag fraction
//   division (log2(EXP_SEGMENTS) + FRACTION_BITS bits, 22 by default) on one
//   shared bit-serial divider, plus the sequencing states. the first request
//   after reset only runs the ratio division. an interval of 16*tau or
//   more skips the second division.
// reset:
//   synchronous; the initial-value registers and tau go to their defaults and
//   the next request is treated as the first one.
// stall:
//   the result sits in an output register; a new request is taken while it
//   waits, and the step only holds in its last state if the result is still
//   not taken by then.
module burner_first_order_lag_sim
   import bfl_pkg::*;
#(
   parameter int FRACTION_BITS = DEF_FRACTION_BITS,
   parameter int EXP_SEGMENTS  = DEF_EXP_SEGMENTS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [TIME_W-1:0]         req_time_ms,
   input  logic signed [TEMP_W-1:0]  req_inlet_temp,
   input  logic [FLOW_W-1:0]         req_flow_rate,
   input  logic [POWER_W-1:0]        req_burner_power,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [TEMP_W-1:0]  rsp_outlet_temp,
   output logic                      rsp_fault,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int F           = FRACTION_BITS;
   localparam int SEG_W       = $clog2(EXP_SEGMENTS + 1);
   localparam int SEGL_W      = $clog2(EXP_SEGMENTS);
   localparam int QW          = SEGL_W + F;
   localparam int QMAX        = (QW > RATIO_W) ? QW : RATIO_W;
   localparam int NF_W        = SPAN_W + SEG_W + F;
   localparam int FRAC_W      = F + 1;
   localparam int PROD_W      = TEMP_W + F + 3;
   localparam int STEP_W      = PROD_W + 1 - F;
   localparam int RES_W       = STEP_W + 1;
   localparam int SUM_W       = RATIO_W + 2;
   localparam int ROUND_SH    = TQ - F;
   localparam int DIFF_W      = TQ + 1;

   localparam logic [FRAC_W-1:0]        FRAC_ONE  = {1'b1, {F{1'b0}}};
   localparam logic [DIFF_W:0]          E_BIAS    = (DIFF_W + 1)'(1) << (ROUND_SH - 1);
   localparam logic signed [PROD_W:0]   STEP_BIAS = (PROD_W + 1)'(1) << (F - 1);
   localparam logic signed [SUM_W-1:0]  SUM_MAX   = SUM_W'(TEMP_MAX);
   localparam logic signed [SUM_W-1:0]  SUM_MIN   = SUM_W'(TEMP_MIN);
   localparam logic signed [RES_W-1:0]  RES_MAX   = RES_W'(TEMP_MAX);
   localparam logic signed [RES_W-1:0]  RES_MIN   = RES_W'(TEMP_MIN);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INIT_INLET  = 2'd0,
      CSR_INIT_FLOW   = 2'd1,
      CSR_INIT_BURNER = 2'd2,
      CSR_TAU         = 2'd3
   } csr_index_type;

   typedef enum logic [11:0] {
      S_IDLE       = 12'b0000_0000_0001,
      S_RATIO_LOAD = 12'b0000_0000_0010,
      S_RATIO_WAIT = 12'b0000_0000_0100,
      S_STEADY     = 12'b0000_0000_1000,
      S_FRAC_LOAD  = 12'b0000_0001_0000,
      S_FRAC_WAIT  = 12'b0000_0010_0000,
      S_NODE_HI    = 12'b0000_0100_0000,
      S_NODE_LO    = 12'b0000_1000_0000,
      S_INTERP     = 12'b0001_0000_0000,
      S_ROUND      = 12'b0010_0000_0000,
      S_STEP_MUL   = 12'b0100_0000_0000,
      S_FINISH     = 12'b1000_0000_0000
   } state_type;

   // control and configuration
   state_type                 state_ff, state_in;
   logic                      first_ff, first_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0]  cfg_inlet_ff, cfg_inlet_in;
   logic [FLOW_W-1:0]         cfg_flow_ff, cfg_flow_in;
   logic [POWER_W-1:0]        cfg_burner_ff, cfg_burner_in;
   logic [TAU_W-1:0]          cfg_tau_ff, cfg_tau_in;

   // plant state
   logic [TIME_W-1:0]         prev_time_ff, prev_time_in;
   logic signed [TEMP_W-1:0]  prev_inlet_ff, prev_inlet_in;
   logic [FLOW_W-1:0]         prev_flow_ff, prev_flow_in;
   logic [POWER_W-1:0]        prev_burner_ff, prev_burner_in;
   logic signed [TEMP_W-1:0]  prev_outlet_ff, prev_outlet_in;

   // held request and step datapath
   logic [TIME_W-1:0]         hold_time_ff, hold_time_in;
   logic signed [TEMP_W-1:0]  hold_inlet_ff, hold_inlet_in;
   logic [FLOW_W-1:0]         hold_flow_ff, hold_flow_in;
   logic [POWER_W-1:0]        hold_burner_ff, hold_burner_in;
   logic [RATIO_W-1:0]        ratio_ff, ratio_in;
   logic signed [TEMP_W-1:0]  steady_ff, steady_in;
   logic                      fault_ff, fault_in;
   logic [SPAN_W-1:0]         dt_ff, dt_in;
   logic [QW-1:0]             u_ff, u_in;
   logic [NODE_W-1:0]         hi_ff, hi_in;
   logic [DIFF_W-1:0]         mul_ff, mul_in;
   logic [FRAC_W-1:0]         frac_ff, frac_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [TEMP_W-1:0]  rsp_outlet_ff, rsp_outlet_in;
   logic                      rsp_fault_ff, rsp_fault_in;

   // combinational helpers
   logic                      req_fire;
   logic                      out_free;
   logic [RATIO_W-1:0]        ratio_num;
   logic [TAU_W-1:0]          tau_eff;
   logic [SPAN_W-1:0]         span;
   logic [TIME_W-1:0]         dt_full;
   logic                      dt_long;
   logic [NF_W-1:0]           frac_num;
   logic [SPAN_W-1:0]         frac_rem0;
   logic [SEGL_W-1:0]         idx;
   logic [SEGL_W-1:0]         quo_idx;
   logic [SEG_W-1:0]          rom_addr;
   logic [NODE_W-1:0]         rom_q;
   logic signed [SUM_W-1:0]   steady_sum;
   logic signed [TEMP_W-1:0]  steady_val;
   logic                      steady_fault;
   logic [DIFF_W-1:0]         node_diff;
   logic [DIFF_W+F-1:0]       mul_full;
   logic [DIFF_W-1:0]         e_val;
   logic [DIFF_W:0]           e_rnd;
   logic [FRAC_W-1:0]         e_frac;
   logic [FRAC_W-1:0]         frac_val;
   logic signed [TEMP_W:0]    delta;
   logic signed [PROD_W-1:0]  prod_val;
   logic signed [PROD_W:0]    step_rnd;
   logic signed [PROD_W:0]    step_shift;
   logic [STEP_W-1:0]         step;
   logic signed [RES_W-1:0]   res_sum;
   logic signed [TEMP_W-1:0]  res_val;

   // shared divider hookup
   div_ctrl_type              div_ctrl;
   div_stat_type              div_stat;
   logic [SPAN_W-1:0]         div_rem_init;
   logic [QMAX-1:0]           div_num;
   logic [SPAN_W-1:0]         div_divisor;
   logic [QMAX-1:0]           div_quo;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // steady state: inlet + round(2560 * burner / flow)
   assign ratio_num = RATIO_W'(prev_burner_ff) * RATIO_W'(HEAT_GAIN)
                      + RATIO_W'(prev_flow_ff >> 1);
   assign steady_sum = $signed({{(SUM_W - TEMP_W){prev_inlet_ff[TEMP_W-1]}}, prev_inlet_ff})
                       + $signed({2'b00, ratio_ff});

   always_comb begin
      steady_val   = steady_sum[TEMP_W-1:0];
      steady_fault = 1'b0;
      if (prev_flow_ff == '0) begin
         steady_val   = TEMP_W'(TEMP_MAX);
         steady_fault = 1'b1;
      end else if (steady_sum > SUM_MAX) begin
         steady_val   = TEMP_W'(TEMP_MAX);
         steady_fault = 1'b1;
      end else if (steady_sum < SUM_MIN) begin
         steady_val   = TEMP_W'(TEMP_MIN);
         steady_fault = 1'b1;
      end
   end

   // lag position u = dt * segments * 2^F / (16 * tau)
   assign tau_eff   = (cfg_tau_ff == '0) ? TAU_W'(1) : cfg_tau_ff;
   assign span      = SPAN_W'(tau_eff) << EXP_RANGE_LOG2;
   assign dt_full   = hold_time_ff - prev_time_ff;
   assign dt_long   = dt_full >= TIME_W'(span);
   assign frac_num  = (NF_W'(dt_ff) * NF_W'(EXP_SEGMENTS)) << F;
   // top part is below span since dt < span, so only QW quotient bits remain
   assign frac_rem0 = SPAN_W'(frac_num >> QW);

   assign idx     = u_ff[QW-1:F];
   assign quo_idx = div_quo[QW-1:F];

   // node hi is fetched first, node lo on the following cycle
   assign rom_addr = (state_ff == S_NODE_HI) ? SEG_W'(idx) : SEG_W'(idx) + SEG_W'(1);

   // linear interpolation between nodes, then round to F bits
   assign node_diff = hi_ff[DIFF_W-1:0] - rom_q[DIFF_W-1:0];
   assign mul_full  = (DIFF_W + F)'(node_diff) * (DIFF_W + F)'(u_ff[F-1:0]);
   assign e_val     = hi_ff[DIFF_W-1:0] - mul_ff;
   assign e_rnd     = ({1'b0, e_val} + E_BIAS) >> ROUND_SH;
   assign e_frac    = (e_rnd > (DIFF_W + 1)'(FRAC_ONE)) ? FRAC_ONE : e_rnd[FRAC_W-1:0];
   assign frac_val  = FRAC_ONE - e_frac;

   // outlet step = round half up of delta * frac / 2^F
   assign delta      = $signed({steady_ff[TEMP_W-1], steady_ff})
                       - $signed({prev_outlet_ff[TEMP_W-1], prev_outlet_ff});
   assign prod_val   = $signed({{(PROD_W - TEMP_W - 1){delta[TEMP_W]}}, delta})
                       * $signed(PROD_W'(frac_ff));
   assign step_rnd   = $signed({prod_ff[PROD_W-1], prod_ff}) + STEP_BIAS;
   assign step_shift = step_rnd >>> F;
   assign step       = step_shift[STEP_W-1:0];
   assign res_sum    = $signed({{(RES_W - TEMP_W){prev_outlet_ff[TEMP_W-1]}}, prev_outlet_ff})
                       + $signed({step[STEP_W-1], step});

   always_comb begin
      if (res_sum > RES_MAX) begin
         res_val = TEMP_W'(TEMP_MAX);
      end else if (res_sum < RES_MIN) begin
         res_val = TEMP_W'(TEMP_MIN);
      end else begin
         res_val = res_sum[TEMP_W-1:0];
      end
   end

   // divider operands: ratio division or lag fraction division
   always_comb begin
      div_ctrl.start = 1'b0;
      div_ctrl.iters = DIV_CNT_W'(RATIO_W);
      div_rem_init   = '0;
      div_num        = QMAX'(ratio_num) << (QMAX - RATIO_W);
      div_divisor    = SPAN_W'(prev_flow_ff);
      if (state_ff == S_RATIO_LOAD) begin
         div_ctrl.start = (prev_flow_ff != '0);
      end else if (state_ff == S_FRAC_LOAD) begin
         div_ctrl.start = 1'b1;
         div_ctrl.iters = DIV_CNT_W'(QW);
         div_rem_init   = frac_rem0;
         div_num        = QMAX'(frac_num[QW-1:0]) << (QMAX - QW);
         div_divisor    = span;
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      first_in       = first_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cfg_inlet_in   = cfg_inlet_ff;
      cfg_flow_in    = cfg_flow_ff;
      cfg_burner_in  = cfg_burner_ff;
      cfg_tau_in     = cfg_tau_ff;
      prev_time_in   = prev_time_ff;
      prev_inlet_in  = prev_inlet_ff;
      prev_flow_in   = prev_flow_ff;
      prev_burner_in = prev_burner_ff;
      prev_outlet_in = prev_outlet_ff;
      hold_time_in   = hold_time_ff;
      hold_inlet_in  = hold_inlet_ff;
      hold_flow_in   = hold_flow_ff;
      hold_burner_in = hold_burner_ff;
      ratio_in       = ratio_ff;
      steady_in      = steady_ff;
      fault_in       = fault_ff;
      dt_in          = dt_ff;
      u_in           = u_ff;
      hi_in          = hi_ff;
      mul_in         = mul_ff;
      frac_in        = frac_ff;
      prod_in        = prod_ff;
      rsp_outlet_in  = rsp_outlet_ff;
      rsp_fault_in   = rsp_fault_ff;

      // register writes
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_INIT_INLET:  cfg_inlet_in  = csr_wdata[TEMP_W-1:0];
            CSR_INIT_FLOW:   cfg_flow_in   = csr_wdata[FLOW_W-1:0];
            CSR_INIT_BURNER: cfg_burner_in = csr_wdata[POWER_W-1:0];
            CSR_TAU:         cfg_tau_in    = csr_wdata[TAU_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               hold_time_in   = req_time_ms;
               hold_inlet_in  = req_inlet_temp;
               hold_flow_in   = req_flow_rate;
               hold_burner_in = req_burner_power;
               // first request works from the initial-value registers
               if (first_ff) begin
                  prev_inlet_in  = cfg_inlet_ff;
                  prev_flow_in   = cfg_flow_ff;
                  prev_burner_in = cfg_burner_ff;
               end
               state_in = S_RATIO_LOAD;
            end
         end
         S_RATIO_LOAD: begin
            // zero flow has no ratio to divide out
            state_in = (prev_flow_ff == '0) ? S_STEADY : S_RATIO_WAIT;
         end
         S_RATIO_WAIT: begin
            if (div_stat.done) begin
               ratio_in = div_quo[RATIO_W-1:0];
               state_in = S_STEADY;
            end
         end
         S_STEADY: begin
            steady_in = steady_val;
            fault_in  = steady_fault;
            if (first_ff) begin
               state_in = S_FINISH;
            end else if (dt_long) begin
               // lag fully settled
               frac_in  = FRAC_ONE;
               state_in = S_STEP_MUL;
            end else begin
               dt_in    = dt_full[SPAN_W-1:0];
               state_in = S_FRAC_LOAD;
            end
         end
         S_FRAC_LOAD: begin
            state_in = S_FRAC_WAIT;
         end
         S_FRAC_WAIT: begin
            if (div_stat.done) begin
               u_in = div_quo[QW-1:0];
               if (SEG_W'(quo_idx) >= SEG_W'(EXP_SEGMENTS)) begin
                  frac_in  = FRAC_ONE;
                  state_in = S_STEP_MUL;
               end else begin
                  state_in = S_NODE_HI;
               end
            end
         end
         S_NODE_HI: begin
            state_in = S_NODE_LO;
         end
         S_NODE_LO: begin
            hi_in    = rom_q;
            state_in = S_INTERP;
         end
         S_INTERP: begin
            mul_in   = mul_full[DIFF_W+F-1:F];
            state_in = S_ROUND;
         end
         S_ROUND: begin
            frac_in  = frac_val;
            state_in = S_STEP_MUL;
         end
         S_STEP_MUL: begin
            prod_in  = prod_val;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fault_in = fault_ff;
               prev_time_in = hold_time_ff;
               if (first_ff) begin
                  rsp_outlet_in  = steady_ff;
                  prev_outlet_in = steady_ff;
               end else begin
                  rsp_outlet_in  = res_val;
                  prev_outlet_in = res_val;
                  prev_inlet_in  = hold_inlet_ff;
                  prev_flow_in   = hold_flow_ff;
                  prev_burner_in = hold_burner_ff;
               end
               first_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         first_ff       <= 1'b1;
         rsp_valid_ff   <= 1'b0;
         cfg_inlet_ff   <= RST_INIT_INLET;
         cfg_flow_ff    <= RST_INIT_FLOW;
         cfg_burner_ff  <= RST_INIT_BURNER;
         cfg_tau_ff     <= RST_TAU;
         prev_time_ff   <= '0;
         prev_inlet_ff  <= '0;
         prev_flow_ff   <= '0;
         prev_burner_ff <= '0;
         prev_outlet_ff <= '0;
      end else begin
         state_ff       <= state_in;
         first_ff       <= first_in;
         rsp_valid_ff   <= rsp_valid_in;
         cfg_inlet_ff   <= cfg_inlet_in;
         cfg_flow_ff    <= cfg_flow_in;
         cfg_burner_ff  <= cfg_burner_in;
         cfg_tau_ff     <= cfg_tau_in;
         prev_time_ff   <= prev_time_in;
         prev_inlet_ff  <= prev_inlet_in;
         prev_flow_ff   <= prev_flow_in;
         prev_burner_ff <= prev_burner_in;
         prev_outlet_ff <= prev_outlet_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_time_ff   <= hold_time_in;
      hold_inlet_ff  <= hold_inlet_in;
      hold_flow_ff   <= hold_flow_in;
      hold_burner_ff <= hold_burner_in;
      ratio_ff       <= ratio_in;
      steady_ff      <= steady_in;
      fault_ff       <= fault_in;
      dt_ff          <= dt_in;
      u_ff           <= u_in;
      hi_ff          <= hi_in;
      mul_ff         <= mul_in;
      frac_ff        <= frac_in;
      prod_ff        <= prod_in;
      rsp_outlet_ff  <= rsp_outlet_in;
      rsp_fault_ff   <= rsp_fault_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outlet_temp = rsp_outlet_ff;
   assign rsp_fault       = rsp_fault_ff;

   bfl_divider #(
      .DIV_W (SPAN_W),
      .QUO_W (QMAX)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .rem_init (div_rem_init),
      .num      (div_num),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   bfl_node_rom #(
      .EXP_SEGMENTS (EXP_SEGMENTS)
   ) u_node_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_q)
   );

   // an accepted request always starts with the ratio stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_RATIO_LOAD)
      else $error("request accepted but sequencer did not start");

   // the divider only runs while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_stat.busy || div_stat.done |-> state_ff == S_RATIO_WAIT || state_ff == S_FRAC_WAIT)
      else $error("divider active outside a wait state");

   // node lookup stays inside the table
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NODE_HI |-> SEG_W'(idx) < SEG_W'(EXP_SEGMENTS))
      else $error("exp node index out of range");

   // lag fraction never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STEP_MUL |-> frac_ff <= FRAC_ONE)
      else $error("lag fraction above one");

   // the first-step flag clears only when its result is posted
   assert property (@(posedge clock) disable iff (reset)
      $fell(first_ff) |-> $past(state_ff == S_FINISH) && rsp_valid)
      else $error("first-step flag cleared without a response");

endmodule
